FILE: design/centered_moving_average_defines.svh
// Assertion macros shared by the centered moving average RTL.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CENTERED_MOVING_AVERAGE_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define CMA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CMA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cma_pkg.sv
// Shared sizes and payload types of the centered moving average.
// Used by the divider, the top level and the testbench; depends on nothing else.
package cma_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SAMPLE_WIDTH = 24;
    localparam int WIN_W        = 6;
    localparam int HIST_DEPTH   = 2 * MAX_WINDOW;
    localparam int PTR_W        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int MAX_SPAN     = 2 * (MAX_WINDOW / 2) + 1;
    localparam int CNT_W        = $clog2(MAX_SPAN + 1);
    localparam int SUM_W        = SAMPLE_WIDTH + $clog2(MAX_SPAN);
    localparam int NUM_W        = SUM_W + 1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] average;
        logic                           last_out;
    } out_t;

endpackage

FILE: design/cma_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the sample history of the centered moving average.
module cma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/cma_div.sv
// Bit-serial restoring divider that forms the rounded mean sum / count.
// Depends on cma_pkg for the sum, count and sample widths.
module cma_div (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [cma_pkg::SUM_W-1:0]        sum,
    input  logic [cma_pkg::CNT_W-1:0]               cnt,
    output logic                                    done,
    output logic signed [cma_pkg::SAMPLE_WIDTH-1:0] average
);

    localparam int NUM_W  = cma_pkg::NUM_W;
    localparam int SUM_W  = cma_pkg::SUM_W;
    localparam int DEN_W  = cma_pkg::CNT_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic              neg_reg;

    logic [SUM_W-1:0]  mag;
    logic [DEN_W:0]    rem_shift;
    logic              take;
    logic [DEN_W:0]    rem_diff;
    logic [NUM_W-1:0]  quo_signed;

    always_comb begin
        mag        = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
        rem_shift  = {rem_reg, num_reg[NUM_W-1]};
        take       = rem_shift >= {1'b0, den_reg};
        rem_diff   = rem_shift - {1'b0, den_reg};
        quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {mag, 1'b0} + NUM_W'(cnt);
            den_reg <= {cnt, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= sum[SUM_W-1];
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= take ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done    = done_reg;
    assign average = quo_signed[cma_pkg::SAMPLE_WIDTH-1:0];

endmodule

FILE: design/centered_moving_average.sv
// Centered moving average: one request at a time. A request is taken only while idle, and the
// next is not taken until the result of the last one, if it has one, has been accepted.
// The final request of a stream also drops samples from the shrinking tail span and flushes
// the remaining results; each result waits on a 31-step shared divider.
// Synchronous active-low reset clears pointers, sums and counters and sets the window to 1;
// the history memory is not cleared.
`include "centered_moving_average_defines.svh"
module centered_moving_average (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [cma_pkg::WIN_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cma_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cma_pkg::out_t             m_data
);

    localparam int SW    = cma_pkg::SAMPLE_WIDTH;
    localparam int PTR_W = cma_pkg::PTR_W;
    localparam int CNT_W = cma_pkg::CNT_W;
    localparam int SUM_W = cma_pkg::SUM_W;
    localparam int DEPTH = cma_pkg::HIST_DEPTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_FCHK,
        S_FSUB,
        S_DIV,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [cma_pkg::WIN_W-1:0] window_reg;
    logic [PTR_W-1:0]          wp_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          rc_reg;
    logic [CNT_W-1:0]          span_reg;
    logic signed [SW-1:0]      x_reg;
    logic                      last_reg;
    logic                      flush_reg;
    logic signed [SUM_W-1:0]   s_reg;
    logic [CNT_W-1:0]          cur_reg;
    logic [CNT_W-1:0]          k_reg;
    logic                      m_valid_reg;
    cma_pkg::out_t             m_data_reg;

    logic [CNT_W-1:0]          w_eff;
    logic [CNT_W-1:0]          span_cfg;
    logic [CNT_W-1:0]          span_sel;
    logic [CNT_W-1:0]          half;
    logic [CNT_W-1:0]          rc_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]          kmax;
    logic [CNT_W:0]            lim;
    logic [CNT_W-1:0]          m_cnt;
    logic                      need_sub;
    logic [CNT_W-1:0]          back_n;
    logic [PTR_W:0]            back_sum;
    logic [PTR_W-1:0]          rd_addr;
    logic [PTR_W-1:0]          wp_inc;
    logic [SW-1:0]             rd_data;
    logic signed [SW-1:0]      rd_sample;
    logic signed [SW-1:0]      sub_sample;
    logic                      wr_en;
    logic                      div_start;
    logic signed [SUM_W-1:0]   div_sum;
    logic [CNT_W-1:0]          div_cnt;
    logic                      div_done;
    logic signed [SW-1:0]      div_avg;

    always_comb begin
        if (window_reg == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(window_reg) > 32'(cma_pkg::MAX_WINDOW)) begin
            w_eff = CNT_W'(cma_pkg::MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(window_reg);
        end
        span_cfg   = w_eff | CNT_W'(1);
        span_sel   = (rc_reg == '0) ? span_cfg : span_reg;
        half       = span_reg >> 1;
        rc_next    = (rc_reg < span_reg) ? rc_reg + CNT_W'(1) : rc_reg;
        rd_sample  = rd_data;
        sub_sample = (rc_reg >= span_reg) ? rd_sample : '0;
        sum_next   = sum_reg + SUM_W'(x_reg) - SUM_W'(sub_sample);
        kmax       = ((rc_next - CNT_W'(1)) < half) ? rc_next - CNT_W'(1) : half;
        lim        = {1'b0, k_reg} + {1'b0, half} + (CNT_W+1)'(1);
        m_cnt      = (lim > {1'b0, rc_reg}) ? rc_reg : lim[CNT_W-1:0];
        need_sub   = cur_reg > m_cnt;
        back_n     = (state_reg == S_IDLE) ? span_sel : cur_reg;
        back_sum   = {1'b0, wp_reg} - (PTR_W+1)'(back_n);
        if (32'(wp_reg) < 32'(back_n)) begin
            back_sum = back_sum + (PTR_W+1)'(DEPTH);
        end
        rd_addr    = back_sum[PTR_W-1:0];
        wp_inc     = (32'(wp_reg) == DEPTH - 1) ? '0 : wp_reg + PTR_W'(1);
        wr_en      = state_reg == S_UPD;
        div_start  = ((state_reg == S_UPD) && !last_reg && (rc_next > half))
                  || ((state_reg == S_FCHK) && !need_sub);
        div_sum    = (state_reg == S_UPD) ? sum_next : s_reg;
        div_cnt    = (state_reg == S_UPD) ? rc_next : cur_reg;
    end

    cma_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (x_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (div_sum),
        .cnt     (div_cnt),
        .done    (div_done),
        .average (div_avg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            window_reg  <= cma_pkg::WIN_W'(1);
            wp_reg      <= '0;
            sum_reg     <= '0;
            rc_reg      <= '0;
            span_reg    <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        span_reg  <= span_sel;
                        x_reg     <= s_data.sample;
                        last_reg  <= s_data.last_in;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    sum_reg <= sum_next;
                    rc_reg  <= rc_next;
                    wp_reg  <= wp_inc;
                    if (last_reg) begin
                        flush_reg <= 1'b1;
                        s_reg     <= sum_next;
                        cur_reg   <= rc_next;
                        k_reg     <= kmax;
                        state_reg <= S_FCHK;
                    end else if (rc_next > half) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FCHK: begin
                    state_reg <= need_sub ? S_FSUB : S_DIV;
                end
                S_FSUB: begin
                    s_reg     <= s_reg - SUM_W'(rd_sample);
                    cur_reg   <= cur_reg - CNT_W'(1);
                    state_reg <= S_FCHK;
                end
                S_DIV: begin
                    if (div_done) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg.average  <= div_avg;
                        m_data_reg.last_out <= flush_reg && (k_reg == '0);
                        state_reg           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (!flush_reg) begin
                            state_reg <= S_IDLE;
                        end else if (k_reg == '0) begin
                            flush_reg <= 1'b0;
                            wp_reg    <= '0;
                            sum_reg   <= '0;
                            rc_reg    <= '0;
                            span_reg  <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg - CNT_W'(1);
                            state_reg <= S_FCHK;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CMA_ASSERT_ALWAYS(a_one_side_open, !(s_ready && m_valid), "input open while result pending")
    `CMA_ASSERT_IMP(a_count_bound, rc_reg != '0, rc_reg <= span_reg, "count exceeds span")
    `CMA_ASSERT_IMP(a_div_in_state, div_done, state_reg == S_DIV, "divider finished out of turn")
    `CMA_ASSERT_NEXT(a_clear_after_last,
        m_valid && m_ready && m_data.last_out,
        rc_reg == '0 && wp_reg == '0 && sum_reg == '0,
        "stream state not cleared")

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the centered moving average: random and directed sample streams are checked
// against a predictor of the clipped centered mean that runs alongside the block.
// Depends on cma_pkg and the centered_moving_average top level only.
module tb_top;

    localparam int TOTAL_REQUESTS = 210;
    localparam int CALM_FROM      = 170;
    localparam int SETTLE_CYCLES  = 150;
    localparam int STALL_LIMIT    = 4000;
    localparam longint MAX_SAMPLE = (64'sd1 <<< (cma_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam longint MIN_SAMPLE = -(64'sd1 <<< (cma_pkg::SAMPLE_WIDTH - 1));

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [cma_pkg::WIN_W-1:0] cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    cma_pkg::in_t              s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    cma_pkg::out_t             m_data;

    cma_pkg::in_t  pending_samples[$];
    cma_pkg::out_t expected_means[$];
    int            queued_count = 0;
    int            pushed_count = 0;
    int            mismatches = 0;
    int            stall_cycles = 0;
    bit            calm = 1'b0;
    int            send_gap = 0;
    int            recv_gap = 0;
    cma_pkg::out_t want;

    // Shadow state of the filter.
    longint                    hist_ring[cma_pkg::HIST_DEPTH];
    int                        wr_ptr = 0;
    int                        held = 0;
    int                        span_len = 0;
    longint                    run_sum = 0;
    logic [cma_pkg::WIN_W-1:0] window_reg = 1;

    centered_moving_average DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int slot_back(int ptr, int n);
        return (ptr + cma_pkg::HIST_DEPTH - n) % cma_pkg::HIST_DEPTH;
    endfunction

    function automatic logic [cma_pkg::SAMPLE_WIDTH-1:0] rounded_mean(longint total,
                                                                       int count);
        longint mag;
        longint q;
        mag = (total < 0) ? -total : total;
        q = (2 * mag + count) / (2 * count);
        if (total < 0) begin
            q = -q;
        end
        return q[cma_pkg::SAMPLE_WIDTH-1:0];
    endfunction

    function automatic void push_mean(longint total, int count, bit fin);
        cma_pkg::out_t r;
        r.average = rounded_mean(total, count);
        r.last_out = fin;
        expected_means.push_back(r);
    endfunction

    function automatic void predict_means(cma_pkg::in_t req);
        longint x;
        longint s;
        int w;
        int half;
        int kmax;
        int cur;
        int m;
        x = {{(64 - cma_pkg::SAMPLE_WIDTH){req.sample[cma_pkg::SAMPLE_WIDTH-1]}}, req.sample};
        if (held == 0) begin
            w = (window_reg == 0) ? 1 : int'(window_reg);
            if (w > cma_pkg::MAX_WINDOW) begin
                w = cma_pkg::MAX_WINDOW;
            end
            span_len = 2 * (w / 2) + 1;
        end
        half = span_len / 2;
        if (held >= span_len) begin
            run_sum -= hist_ring[slot_back(wr_ptr, span_len)];
        end
        hist_ring[wr_ptr] = x;
        wr_ptr = (wr_ptr + 1) % cma_pkg::HIST_DEPTH;
        run_sum += x;
        if (held < span_len) begin
            held++;
        end
        if (!req.last_in) begin
            if (held > half) begin
                push_mean(run_sum, held, 1'b0);
            end
        end else begin
            // The final request flushes the tail, shrinking the span from its oldest end.
            kmax = (held - 1 < half) ? held - 1 : half;
            cur = held;
            s = run_sum;
            for (int k = kmax; k >= 0; k--) begin
                m = k + 1 + half;
                if (m > held) begin
                    m = held;
                end
                while (cur > m) begin
                    s -= hist_ring[slot_back(wr_ptr, cur)];
                    cur--;
                end
                push_mean(s, cur, k == 0);
            end
            wr_ptr = 0;
            run_sum = 0;
            held = 0;
            span_len = 0;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_means(s_data);
                queued_count--;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_data <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_means.size() == 0) begin
                    $display("%0t: unexpected result: average %0d last %0b", $time,
                             $signed(m_data.average), m_data.last_out);
                    mismatches++;
                end else begin
                    want = expected_means.pop_front();
                    if (m_data.average !== want.average) begin
                        $display("%0t: average mismatch: expected %0d, actual %0d", $time,
                                 $signed(want.average), $signed(m_data.average));
                        mismatches++;
                    end
                    if (m_data.last_out !== want.last_out) begin
                        $display("%0t: last_out mismatch: expected %0b, actual %0b", $time,
                                 want.last_out, m_data.last_out);
                        mismatches++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) begin
                    recv_gap = $urandom_range(1, 7);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, stall_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_sample(longint v, bit fin);
        cma_pkg::in_t r;
        r.sample = v[cma_pkg::SAMPLE_WIDTH-1:0];
        r.last_in = fin;
        pending_samples.push_back(r);
        queued_count++;
        pushed_count++;
    endtask

    // Holds until every request is taken and every result is back, then lets the tail
    // of any work that produces no result finish.
    task automatic wait_settled();
        do begin
            @(posedge aclk);
        end while (queued_count != 0 || expected_means.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(logic [cma_pkg::WIN_W-1:0] value);
        wait_settled();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        window_reg = value;
    endtask

    function automatic longint draw_sample();
        case ($urandom_range(0, 9))
            0: return MAX_SAMPLE;
            1: return MIN_SAMPLE;
            2: return longint'($urandom_range(0, 8)) - 4;
            default: return longint'($urandom) & ((64'd1 << cma_pkg::SAMPLE_WIDTH) - 1);
        endcase
    endfunction

    initial begin
        int w;
        int len;
        int phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Window 1 after reset passes each sample through.
        push_sample(MAX_SAMPLE, 1'b0);
        push_sample(MIN_SAMPLE, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(1, 1'b0);
        push_sample(MAX_SAMPLE, 1'b1);

        // A zero window acts as one; a one-sample stream returns that sample.
        write_window(cma_pkg::WIN_W'(0));
        push_sample(MAX_SAMPLE, 1'b1);

        // Largest window with a stream shorter than half the span.
        write_window(cma_pkg::WIN_W'(cma_pkg::MAX_WINDOW));
        push_sample(MIN_SAMPLE, 1'b0);
        push_sample(MIN_SAMPLE, 1'b0);
        push_sample(MAX_SAMPLE, 1'b1);

        // An oversized window saturates, and a change mid-stream waits for the next stream.
        write_window(cma_pkg::WIN_W'(63));
        push_sample(MAX_SAMPLE, 1'b0);
        push_sample(MAX_SAMPLE, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(MIN_SAMPLE, 1'b0);
        push_sample(7, 1'b0);
        write_window(cma_pkg::WIN_W'(4));
        push_sample(MIN_SAMPLE, 1'b0);
        push_sample(-5, 1'b0);
        push_sample(MAX_SAMPLE, 1'b0);
        push_sample(2, 1'b1);

        // An even window spans one more sample; halves round away from zero.
        write_window(cma_pkg::WIN_W'(2));
        push_sample(1, 1'b0);
        push_sample(-2, 1'b0);
        push_sample(0, 1'b0);
        push_sample(1, 1'b1);

        phase = 0;
        while (pushed_count < TOTAL_REQUESTS) begin
            case (phase)
                0: w = cma_pkg::MAX_WINDOW;
                1: w = 0;
                2: w = 63;
                3: w = 1;
                default: w = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 63)
                                                          : $urandom_range(0, cma_pkg::MAX_WINDOW);
            endcase
            write_window(w[cma_pkg::WIN_W-1:0]);
            calm = (pushed_count >= CALM_FROM);
            repeat ($urandom_range(1, 4)) begin
                if (pushed_count < TOTAL_REQUESTS) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 45)
                                                      : $urandom_range(1, 10);
                    if (len > TOTAL_REQUESTS - pushed_count) begin
                        len = TOTAL_REQUESTS - pushed_count;
                    end
                    for (int i = 0; i < len; i++) begin
                        push_sample(draw_sample(), i == len - 1);
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        wait_settled();
                    end
                end
            end
            phase++;
        end

        wait_settled();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/cma_pkg.sv
design/cma_ram.sv
design/cma_div.sv
design/centered_moving_average.sv
tb/sv/tb_top.sv
